### sv/pat_pkg.sv
`default_nettype none

package pat_pkg;

  localparam int AddrW  = 48;
  localparam int CountW = 5;

  localparam logic [1:0] ActAdd    = 2'd0;
  localparam logic [1:0] ActRemove = 2'd1;
  localparam logic [1:0] ActQuery  = 2'd2;
  localparam logic [1:0] ActClear  = 2'd3;

  localparam logic [CountW-1:0] CountMax = 5'd31;

  typedef struct packed {
    logic [1:0]       action;
    logic [AddrW-1:0] mac_address;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [CountW-1:0] entry_count;
  } rsp_t;

endpackage

`default_nettype wire

### sv/peer_address_table_top.sv
`default_nettype none

// Station address table: TABLE_SLOTS 48-bit addresses kept in a single-port-read
// RAM, with one valid flop per slot and a running count of valid slots. Every
// request (add, remove, query, clear) returns one word with a success flag and
// the valid count after the action, saturated at 31. Add, remove and query walk
// the RAM one slot per cycle through its one read port, then register the result
// in the finish state; clear skips the walk and goes straight to finish, which
// waits while an earlier result is held and out_ready is low. One request is
// worked at a time; the next can be accepted as soon as the previous result is
// registered, even while it still waits on out_ready.
module peer_address_table_top #(
  parameter int TABLE_SLOTS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire pat_pkg::req_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output pat_pkg::rsp_t      out_data
);

  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
  localparam int SAT_W = (CNT_W > pat_pkg::CountW) ? CNT_W : pat_pkg::CountW;
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(TABLE_SLOTS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t                   state_r;
  pat_pkg::req_t            req_r;
  logic [TABLE_SLOTS-1:0]   valid_r;
  logic [CNT_W-1:0]         count_r;
  logic [IDX_W-1:0]         rd_idx_r;
  logic                     issue_done_r;
  logic                     cmp_vld_r;
  logic [IDX_W-1:0]         cmp_idx_r;
  logic                     hit_r;
  logic [IDX_W-1:0]         hit_idx_r;
  logic                     free_r;
  logic [IDX_W-1:0]         free_idx_r;
  logic                     out_valid_r;
  pat_pkg::rsp_t            out_data_r;

  logic                     issue;
  logic                     ram_we;
  logic [pat_pkg::AddrW-1:0] rd_data;
  logic                     cmp_hit;
  logic                     out_free;
  logic                     fin_ok;
  logic [CNT_W-1:0]         count_nxt;
  logic [TABLE_SLOTS-1:0]   valid_nxt;
  logic [SAT_W-1:0]         count_wide;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  assign issue   = (state_r == ST_SCAN) && !issue_done_r;
  assign cmp_hit = cmp_vld_r && valid_r[cmp_idx_r] && (rd_data == req_r.mac_address);
  assign ram_we  = (state_r == ST_FINISH) && out_free && (req_r.action == pat_pkg::ActAdd)
                   && !hit_r && free_r;

  pat_ram #(
    .WIDTH (pat_pkg::AddrW),
    .DEPTH (TABLE_SLOTS)
  ) u_addr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx_r),
    .wdata (req_r.mac_address),
    .raddr (rd_idx_r),
    .rdata (rd_data)
  );

  // outcome of the finished request
  always_comb begin
    fin_ok    = 1'b0;
    count_nxt = count_r;
    valid_nxt = valid_r;
    case (req_r.action)
      pat_pkg::ActAdd: begin
        if (hit_r) begin
          fin_ok = 1'b1;
        end else if (free_r) begin
          fin_ok                = 1'b1;
          valid_nxt[free_idx_r] = 1'b1;
          count_nxt             = count_r + CNT_W'(1);
        end
      end
      pat_pkg::ActRemove: begin
        if (hit_r) begin
          fin_ok               = 1'b1;
          valid_nxt[hit_idx_r] = 1'b0;
          count_nxt            = count_r - CNT_W'(1);
        end
      end
      pat_pkg::ActQuery: begin
        fin_ok = hit_r;
      end
      default: begin
        fin_ok    = 1'b1;
        valid_nxt = '0;
        count_nxt = '0;
      end
    endcase
  end

  assign count_wide = SAT_W'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      count_r      <= '0;
      rd_idx_r     <= '0;
      issue_done_r <= 1'b0;
      cmp_vld_r    <= 1'b0;
      hit_r        <= 1'b0;
      free_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // in finish the result register is reloaded below
      if (out_valid_r && out_ready && (state_r != ST_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      cmp_vld_r <= issue;
      cmp_idx_r <= rd_idx_r;
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            req_r        <= in_data;
            rd_idx_r     <= '0;
            issue_done_r <= 1'b0;
            hit_r        <= 1'b0;
            free_r       <= 1'b0;
            state_r      <= (in_data.action == pat_pkg::ActClear) ? ST_FINISH : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            if (rd_idx_r == LastIdx) begin
              issue_done_r <= 1'b1;
            end else begin
              rd_idx_r <= rd_idx_r + IDX_W'(1);
            end
          end
          if (cmp_hit && !hit_r) begin
            hit_r     <= 1'b1;
            hit_idx_r <= cmp_idx_r;
          end
          // lowest free slot is the first invalid one seen
          if (cmp_vld_r && !valid_r[cmp_idx_r] && !free_r) begin
            free_r     <= 1'b1;
            free_idx_r <= cmp_idx_r;
          end
          if (cmp_vld_r && cmp_idx_r == LastIdx) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            valid_r                <= valid_nxt;
            count_r                <= count_nxt;
            out_valid_r            <= 1'b1;
            out_data_r.ok          <= fin_ok;
            out_data_r.entry_count <= (count_wide > SAT_W'(pat_pkg::CountMax))
                                      ? pat_pkg::CountMax
                                      : count_wide[pat_pkg::CountW-1:0];
            state_r                <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CNT_W'($countones(valid_r)))
    else $error("valid count does not match valid flags");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    SAT_W'(count_r) <= SAT_W'(TABLE_SLOTS))
    else $error("valid count above table size");

  a_compare_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> (state_r == ST_SCAN))
    else $error("slot compare outside scan");

  a_write_once_per_finish: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (state_r == ST_IDLE) && out_valid_r && out_data_r.ok)
    else $error("table write without a successful add result");

endmodule

`default_nettype wire

### sv/pat_ram.sv
`default_nettype none

module pat_ram #(
  parameter int WIDTH  = 48,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
